// ===== rtl/scar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scar_pkg
// shared types and constants of the stereo comb/allpass reverb
// ----------------------------------------------------------------------------
package scar_pkg;

	// coefficient operand width of the shared multiplier, signed q1.15 plus headroom
	localparam int COEF_W = 17;

	localparam logic [16:0] UNITY      = 17'd32768;
	localparam logic [16:0] FEED_SUM_K = 17'd6554;
	localparam logic [16:0] FEED_DIF_K = 17'd26214;

	// configuration register indexes
	localparam logic [1:0] REG_ROOM = 2'd0;
	localparam logic [1:0] REG_DAMP = 2'd1;
	localparam logic [1:0] REG_WET  = 2'd2;

	localparam logic [14:0] ROOM_RST = 15'd27525;
	localparam logic [15:0] DAMP_RST = 16'd16384;
	localparam logic [15:0] WET_RST  = 16'd0;

	localparam int COMB_BASE [4] = '{1557, 1617, 1491, 1422};
	localparam int AP_BASE [2]   = '{225, 556};

	typedef struct packed {
		logic en;
		logic clr;
	} mac_ctl_t;

endpackage

// ===== rtl/stereo_comb_allpass_reverb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_comb_allpass_reverb
// freeverb-style stereo reverb: 8 damped comb lines, 4 allpass stages, wet mix
// ----------------------------------------------------------------------------
//  channel | signals                             | transaction
//  --------+-------------------------------------+-------------------------
//  input   | in_valid, in_ready, left/right_in   | one stereo frame
//  output  | out_valid, out_ready, left/right_out| one reverberated frame
//  config  | cfg_valid, cfg_ready, index, data   | one register write
//
// a frame steps through the feed states F0-F2, C0-C5 for each of the 8 comb lines,
// A0-A1 for each of the 4 allpass stages, M0-M5 for the wet/dry mix and DONE for the hand-off;
// in_ready returns the cycle after the hand-off, so a new frame waits for that hand-off
// every product goes through the single shared multiplier
// after reset the delay memories are swept to zero over all 8 << clog2(COMB_LINE_DEPTH)
// comb addresses, with in_ready low; config writes are taken during the sweep
// config writes are taken only while idle and no frame is offered
// a stalled output holds the finished frame; the next frame may be accepted meanwhile
// ----------------------------------------------------------------------------
module stereo_comb_allpass_reverb #(
	parameter int COMB_LINE_DEPTH       = 2048,
	parameter int ALLPASS_LINE_DEPTH    = 1024,
	parameter int COMB_STEREO_SPREAD    = 23,
	parameter int ALLPASS_STEREO_SPREAD = 11,
	parameter int SAMPLE_BITS           = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] left_in,
	input  logic signed [SAMPLE_BITS-1:0] right_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [15:0]                   cfg_data
);
	import scar_pkg::*;

	localparam int LINE_BITS = SAMPLE_BITS + 4;
	localparam int AW        = LINE_BITS + 1;
	localparam int ACCW      = AW + COEF_W + 1;
	localparam int CPW       = $clog2(COMB_LINE_DEPTH);
	localparam int APW       = $clog2(ALLPASS_LINE_DEPTH);
	localparam int SUMW      = LINE_BITS + 2;

	// sequencer codes
	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_F0   = 5'd1;
	localparam logic [4:0] ST_F1   = 5'd2;
	localparam logic [4:0] ST_F2   = 5'd3;
	localparam logic [4:0] ST_C0   = 5'd4;
	localparam logic [4:0] ST_C1   = 5'd5;
	localparam logic [4:0] ST_C2   = 5'd6;
	localparam logic [4:0] ST_C3   = 5'd7;
	localparam logic [4:0] ST_C4   = 5'd8;
	localparam logic [4:0] ST_C5   = 5'd9;
	localparam logic [4:0] ST_A0   = 5'd10;
	localparam logic [4:0] ST_A1   = 5'd11;
	localparam logic [4:0] ST_M0   = 5'd12;
	localparam logic [4:0] ST_M1   = 5'd13;
	localparam logic [4:0] ST_M2   = 5'd14;
	localparam logic [4:0] ST_M3   = 5'd15;
	localparam logic [4:0] ST_M4   = 5'd16;
	localparam logic [4:0] ST_M5   = 5'd17;
	localparam logic [4:0] ST_DONE = 5'd18;

	localparam logic signed [ACCW-1:0] LINE_MAX = ACCW'((64'sd1 <<< (LINE_BITS-1)) - 1);
	localparam logic signed [ACCW-1:0] LINE_MIN = -LINE_MAX - ACCW'(1);
	localparam logic signed [ACCW-1:0] SMP_MAX  = ACCW'((64'sd1 <<< (SAMPLE_BITS-1)) - 1);
	localparam logic signed [ACCW-1:0] SMP_MIN  = -SMP_MAX - ACCW'(1);

	function automatic logic signed [LINE_BITS-1:0] sat_line(input logic signed [ACCW-1:0] v);
		if (v > LINE_MAX) return LINE_MAX[LINE_BITS-1:0];
		if (v < LINE_MIN) return LINE_MIN[LINE_BITS-1:0];
		return v[LINE_BITS-1:0];
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(input logic signed [ACCW-1:0] v);
		if (v > SMP_MAX) return SMP_MAX[SAMPLE_BITS-1:0];
		if (v < SMP_MIN) return SMP_MIN[SAMPLE_BITS-1:0];
		return v[SAMPLE_BITS-1:0];
	endfunction

	function automatic logic [CPW:0] comb_len(input logic [2:0] k);
		int n;
		n = COMB_BASE[k[1:0]] + (k[2] ? COMB_STEREO_SPREAD : 0);
		if (n > COMB_LINE_DEPTH) n = COMB_LINE_DEPTH;
		return (CPW+1)'(n);
	endfunction

	function automatic logic [APW:0] ap_len(input logic [1:0] k);
		int n;
		n = AP_BASE[k[0]] + (k[1] ? ALLPASS_STEREO_SPREAD : 0);
		if (n > ALLPASS_LINE_DEPTH) n = ALLPASS_LINE_DEPTH;
		return (APW+1)'(n);
	endfunction

	// registers
	logic [4:0]  state_q;
	logic [2:0]  k_q;
	logic        clearing_q;
	logic [CPW+2:0] clr_q;
	logic [14:0] room_q;
	logic [15:0] damp_q;
	logic [15:0] wet_q;

	logic signed [SAMPLE_BITS-1:0] l_q, r_q;
	logic signed [LINE_BITS-1:0]   feed_q;
	logic signed [SUMW-1:0]        sum_l_q, sum_r_q;
	logic signed [LINE_BITS-1:0]   store_q [8];
	logic [CPW-1:0]                cpos_q [8];
	logic [APW-1:0]                apos_q [4];
	logic signed [LINE_BITS-1:0]   x_q, wl_q, wr_q;
	logic signed [SAMPLE_BITS-1:0] lo_q, ro_q;
	logic signed [SAMPLE_BITS-1:0] left_out_q, right_out_q;
	logic                          out_valid_q;

	// delay memories
	logic signed [LINE_BITS-1:0] cmem [0:(8 << CPW)-1];
	logic signed [LINE_BITS-1:0] amem [0:(4 << APW)-1];
	logic signed [LINE_BITS-1:0] cm_rdata, am_rdata;
	logic [CPW+2:0] cm_raddr, cm_waddr;
	logic [APW+1:0] am_raddr, am_waddr;
	logic           cm_we, am_we;
	logic signed [LINE_BITS-1:0] cm_wdata, am_wdata;

	// shared multiplier
	mac_ctl_t                  mac_ctl;
	logic signed [AW-1:0]      mac_a;
	logic signed [COEF_W-1:0]  mac_b;
	logic signed [ACCW-1:0]    acc;

	scar_mac #(.AW(AW)) u_mac (
		.clk (clk),
		.ctl (mac_ctl),
		.a   (mac_a),
		.b   (mac_b),
		.acc (acc)
	);

	// rounded views of the accumulator and derived values
	logic signed [ACCW-1:0] rnd15, rnd16;
	logic signed [ACCW-1:0] line_wr, ap_in, ap_out;
	logic signed [SUMW-1:0] avg_l, avg_r;
	logic [CPW:0]           cp_inc;
	logic [APW:0]           ap_inc;
	logic [16:0]            dry;
	logic                   out_load;

	assign rnd15   = (acc + (ACCW'(1) <<< 14)) >>> 15;
	assign rnd16   = (acc + (ACCW'(1) <<< 15)) >>> 16;
	assign line_wr = ACCW'(feed_q) + rnd15;
	assign ap_in   = ACCW'(x_q) + ((ACCW'(am_rdata) + ACCW'(1)) >>> 1);
	assign ap_out  = ACCW'(am_rdata) - ACCW'(x_q);
	assign avg_l   = (sum_l_q + SUMW'(2)) >>> 2;
	assign avg_r   = (sum_r_q + SUMW'(2)) >>> 2;
	assign cp_inc  = {1'b0, cpos_q[k_q]} + (CPW+1)'(1);
	assign ap_inc  = {1'b0, apos_q[k_q[1:0]]} + (APW+1)'(1);
	assign dry     = UNITY - {1'b0, wet_q};

	// finished frame moves into the output register once it is free
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// memory addressing: sweep during clear, line/position otherwise
	assign cm_raddr = {k_q, cpos_q[k_q]};
	assign am_raddr = {k_q[1:0], apos_q[k_q[1:0]]};
	assign cm_we    = clearing_q || (state_q == ST_C5);
	assign cm_waddr = clearing_q ? clr_q : cm_raddr;
	assign cm_wdata = clearing_q ? '0 : sat_line(line_wr);
	assign am_we    = clearing_q || (state_q == ST_A1);
	assign am_waddr = clearing_q ? clr_q[APW+1:0] : am_raddr;
	assign am_wdata = clearing_q ? '0 : sat_line(ap_in);

	always_ff @(posedge clk) begin
		if (cm_we) begin
			cmem[cm_waddr] <= cm_wdata;
		end
		cm_rdata <= cmem[cm_raddr];
	end

	always_ff @(posedge clk) begin
		if (am_we) begin
			amem[am_waddr] <= am_wdata;
		end
		am_rdata <= amem[am_raddr];
	end

	// operand selection for the shared multiplier
	always_comb begin
		mac_ctl = '{en: 1'b0, clr: 1'b0};
		mac_a   = '0;
		mac_b   = '0;
		unique case (state_q)
			ST_F0: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1};
				mac_a   = AW'(l_q) + AW'(r_q);
				mac_b   = FEED_SUM_K;
			end
			ST_F1: begin
				mac_ctl = '{en: 1'b1, clr: 1'b0};
				mac_a   = AW'(l_q) - AW'(r_q);
				mac_b   = FEED_DIF_K;
			end
			ST_C1: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1};
				mac_a   = AW'(cm_rdata);
				mac_b   = UNITY - {1'b0, damp_q};
			end
			ST_C2: begin
				mac_ctl = '{en: 1'b1, clr: 1'b0};
				mac_a   = AW'(store_q[k_q]);
				mac_b   = {1'b0, damp_q};
			end
			ST_C4: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1};
				mac_a   = AW'(store_q[k_q]);
				mac_b   = {2'b00, room_q};
			end
			ST_M0: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1};
				mac_a   = AW'(l_q);
				mac_b   = dry;
			end
			ST_M1: begin
				mac_ctl = '{en: 1'b1, clr: 1'b0};
				mac_a   = AW'(wl_q);
				mac_b   = {1'b0, wet_q};
			end
			ST_M3: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1};
				mac_a   = AW'(r_q);
				mac_b   = dry;
			end
			ST_M4: begin
				mac_ctl = '{en: 1'b1, clr: 1'b0};
				mac_a   = AW'(wr_q);
				mac_b   = {1'b0, wet_q};
			end
			default: begin
				mac_ctl = '{en: 1'b0, clr: 1'b0};
			end
		endcase
	end

	// configuration registers, damping and wet above one clamp to one, room keeps its low 15 bits
	// writes wait while a frame is in flight or offered
	assign cfg_ready = (state_q == ST_IDLE) && !in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_q <= ROOM_RST;
			damp_q <= DAMP_RST;
			wet_q  <= WET_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROOM: room_q <= cfg_data[14:0];
				REG_DAMP: damp_q <= (cfg_data > UNITY[15:0]) ? UNITY[15:0] : cfg_data;
				REG_WET:  wet_q  <= (cfg_data > UNITY[15:0]) ? UNITY[15:0] : cfg_data;
				default: ;
			endcase
		end
	end

	// post-reset memory sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + (CPW+3)'(1);
			if (&clr_q) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign in_ready = (state_q == ST_IDLE) && !clearing_q;

	// control state: sequencer, positions, damping stores
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				store_q[i] <= '0;
				cpos_q[i]  <= '0;
			end
			for (int i = 0; i < 4; i++) begin
				apos_q[i] <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (in_valid && in_ready) state_q <= ST_F0;
				ST_F0:   state_q <= ST_F1;
				ST_F1:   state_q <= ST_F2;
				ST_F2: begin
					k_q     <= '0;
					state_q <= ST_C0;
				end
				ST_C0:   state_q <= ST_C1;
				ST_C1:   state_q <= ST_C2;
				ST_C2:   state_q <= ST_C3;
				ST_C3: begin
					store_q[k_q] <= sat_line(rnd15);
					state_q      <= ST_C4;
				end
				ST_C4:   state_q <= ST_C5;
				ST_C5: begin
					cpos_q[k_q] <= (cp_inc >= comb_len(k_q)) ? '0 : cp_inc[CPW-1:0];
					k_q         <= k_q + 3'd1;
					state_q     <= (k_q == 3'd7) ? ST_A0 : ST_C0;
				end
				ST_A0:   state_q <= ST_A1;
				ST_A1: begin
					apos_q[k_q[1:0]] <= (ap_inc >= ap_len(k_q[1:0])) ? '0 : ap_inc[APW-1:0];
					k_q              <= k_q + 3'd1;
					state_q          <= (k_q == 3'd3) ? ST_M0 : ST_A0;
				end
				ST_M0:   state_q <= ST_M1;
				ST_M1:   state_q <= ST_M2;
				ST_M2:   state_q <= ST_M3;
				ST_M3:   state_q <= ST_M4;
				ST_M4:   state_q <= ST_M5;
				ST_M5:   state_q <= ST_DONE;
				ST_DONE: begin
					// hand off once the output register is free
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			l_q <= left_in;
			r_q <= right_in;
		end
		case (state_q)
			ST_F0: begin
				sum_l_q <= '0;
				sum_r_q <= '0;
			end
			ST_F2: feed_q <= rnd16[LINE_BITS-1:0];
			ST_C1: begin
				if (k_q[2]) sum_r_q <= sum_r_q + SUMW'(cm_rdata);
				else        sum_l_q <= sum_l_q + SUMW'(cm_rdata);
			end
			ST_C5: if (k_q == 3'd7) x_q <= avg_l[LINE_BITS-1:0];
			ST_A1: begin
				if (k_q == 3'd1) begin
					wl_q <= sat_line(ap_out);
					x_q  <= avg_r[LINE_BITS-1:0];
				end else if (k_q == 3'd3) begin
					wr_q <= sat_line(ap_out);
				end else begin
					x_q <= sat_line(ap_out);
				end
			end
			ST_M2: lo_q <= sat_smp(rnd15);
			ST_M5: ro_q <= sat_smp(rnd15);
			ST_DONE: begin
				if (out_load) begin
					left_out_q  <= lo_q;
					right_out_q <= ro_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign left_out  = left_out_q;
	assign right_out = right_out_q;

endmodule

// ===== rtl/scar_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scar_mac
// shared multiply-accumulate unit, one product per cycle while enabled into a registered sum
// ----------------------------------------------------------------------------
module scar_mac #(
	parameter int AW = 29
) (
	input  logic                           clk,
	input  scar_pkg::mac_ctl_t             ctl,
	input  logic signed [AW-1:0]           a,
	input  logic signed [scar_pkg::COEF_W-1:0] b,
	output logic signed [AW+scar_pkg::COEF_W:0] acc
);
	import scar_pkg::*;

	localparam int ACCW = AW + COEF_W + 1;

	logic signed [AW+COEF_W-1:0] prod;
	logic signed [ACCW-1:0]      acc_q;

	assign prod = a * b;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= (ctl.clr ? ACCW'(0) : acc_q) + ACCW'(prod);
		end
	end

	assign acc = acc_q;

endmodule

// ===== rtl/scar_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scar_checker
// port-level checks of the reverb's transaction sequencing
// ----------------------------------------------------------------------------
module scar_checker #(
	parameter int SAMPLE_BITS = 24
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] left_out,
	input logic [SAMPLE_BITS-1:0] right_out,
	input logic                   cfg_valid,
	input logic                   cfg_ready
);

	// one frame at a time: accepting a frame drops ready
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready stayed high after an input transaction");

	// a result never follows its frame on the very next cycle
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !$rose(out_valid))
		else $error("result appeared one cycle after input transaction");

	// a result is raised only while the block's input is free
	a_result_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result raised while input still busy");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(left_out) && $stable(right_out)))
		else $error("stalled result changed");

	// a register write never shares an edge with a frame
	a_cfg_apart: assert property (@(posedge clk) disable iff (!arst_n)
		!(cfg_valid && cfg_ready && in_valid && in_ready))
		else $error("config and input transactions on the same edge");

endmodule

bind stereo_comb_allpass_reverb scar_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_scar_checker (.*);
